// ===== rtl/core/mmre_pkg.sv =====
// ----------------------------------------------------------------------------
// mmre_pkg: shared types and constants of the matrix row engine
// Matrix sizes, command codes, sequencer states and the token and write
// structs that travel between the sequencer, the cell chain and the queue.
// ----------------------------------------------------------------------------
package mmre_pkg;

	// Matrix dimensions: A is ROWS x INNER, B is INNER x COLS.
	localparam int ROWS  = 16;
	localparam int INNER = 16;
	localparam int COLS  = 16;

	// Index fields are 4 bits wide, so at most 16 columns are emitted.
	localparam int IDX_W    = 4;
	localparam int MAX_EMIT = 16;
	localparam int NEMIT    = (COLS < MAX_EMIT) ? COLS : MAX_EMIT;

	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = 36;

	localparam int FIFO_AW = $clog2(MAX_EMIT);

	typedef enum logic [1:0] {
		CMD_WR_A = 2'd0,
		CMD_WR_B = 2'd1,
		CMD_COMP = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN
	} seq_state_t;

	// Element write broadcast to every cell.
	typedef struct packed {
		logic                    a_en;
		logic                    b_en;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} wr_t;

	// Column token that walks the chain beside its partial sum.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] col;
		logic             last;
	} tok_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

// ===== rtl/core/mmre_req_if.sv =====
// ----------------------------------------------------------------------------
// mmre_req_if: request channel of the matrix row engine
// Valid/ready handshake carrying one command with its indices and value.
// ----------------------------------------------------------------------------
interface mmre_req_if import mmre_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              cmd;
	logic [IDX_W-1:0]        row;
	logic [IDX_W-1:0]        col;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output cmd, output row, output col, output value,
		input ready);
	modport sink (input valid, input cmd, input row, input col, input value,
		output ready);
endinterface

// ===== rtl/core/mmre_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mmre_rsp_if: result channel of the matrix row engine
// Valid/ready handshake carrying one C element, its column and the row end.
// ----------------------------------------------------------------------------
interface mmre_rsp_if import mmre_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] product_value;
	logic [IDX_W-1:0]        out_col;
	logic                    last;

	modport source (output valid, output product_value, output out_col, output last,
		input ready);
	modport sink (input valid, input product_value, input out_col, input last,
		output ready);
endinterface

// ===== rtl/core/mmre_cell.sv =====
// ----------------------------------------------------------------------------
// mmre_cell: one multiply-accumulate cell of the chain
// Holds column k of A and row k of B, adds A[r][k]*B[k][j] to the partial
// sum passing through. Three register stages: B read, multiply, add.
// ----------------------------------------------------------------------------
module mmre_cell import mmre_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [IDX_W-1:0]        k_idx,
	input  wr_t                     wr,
	input  logic [IDX_W-1:0]        row_sel,
	input  tok_t                    tok_in,
	input  logic signed [ACC_W-1:0] psum_in,
	output tok_t                    tok_out,
	output logic signed [ACC_W-1:0] psum_out
);

	logic signed [VAL_W-1:0]  a_mem [ROWS];
	logic signed [VAL_W-1:0]  b_mem [COLS];
	logic signed [VAL_W-1:0]  a_q;
	logic signed [VAL_W-1:0]  b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  psum_s1, psum_s2, psum_s3;
	tok_t                     tok_s1, tok_s2, tok_s3;

	// Local stores, registered reads
	always_ff @(posedge clk) begin
		if (wr.a_en && wr.col == k_idx) begin
			a_mem[wr.row] <= wr.value;
		end
		if (wr.b_en && wr.row == k_idx) begin
			b_mem[wr.col] <= wr.value;
		end
		a_q  <= a_mem[row_sel];
		b_s1 <= b_mem[tok_in.col];
	end

	// Payload stages
	always_ff @(posedge clk) begin
		psum_s1 <= psum_in;
		prod_s2 <= a_q * b_s1;
		psum_s2 <= psum_s1;
		psum_s3 <= psum_s2 + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
		end
	end

	assign tok_out  = tok_s3;
	assign psum_out = psum_s3;

endmodule

// ===== rtl/core/mmre_seq.sv =====
// ----------------------------------------------------------------------------
// mmre_seq: command sequencer
// Takes requests, broadcasts element writes, and for a compute selects the
// A row and feeds one column token per cycle into the cell chain.
// ----------------------------------------------------------------------------
module mmre_seq import mmre_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	mmre_req_if.sink         req,
	input  fifo_stat_t       fifo_stat,
	input  tok_t             chain_tok,
	output wr_t              wr,
	output logic [IDX_W-1:0] row_sel,
	output tok_t             tok
);

	seq_state_t       state_q, state_nxt;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic             accept;
	logic             is_comp;
	logic             issue_last;

	assign accept     = req.valid && req.ready;
	assign is_comp    = (req.cmd == CMD_COMP) && (int'(req.row) < ROWS);
	assign issue_last = (col_q == IDX_W'(NEMIT - 1));

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_comp) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (fifo_stat.empty) begin
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (issue_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (chain_tok.valid && chain_tok.last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req.ready = 1'b0;
		tok       = '0;
		wr.row    = req.row;
		wr.col    = req.col;
		wr.value  = req.value;
		wr.a_en   = 1'b0;
		wr.b_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				wr.a_en = req.valid && (req.cmd == CMD_WR_A) &&
					(int'(req.row) < ROWS) && (int'(req.col) < INNER);
				wr.b_en = req.valid && (req.cmd == CMD_WR_B) &&
					(int'(req.row) < INNER) && (int'(req.col) < COLS);
			end
			ST_ISSUE: begin
				tok.valid = 1'b1;
				tok.col   = col_q;
				tok.last  = issue_last;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign row_sel = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept && is_comp) begin
				row_q <= req.row;
			end
			if (state_q == ST_ISSUE) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/mmre_fifo.sv =====
// ----------------------------------------------------------------------------
// mmre_fifo: result queue
// Holds one full row of C so the chain never has to stall.
// ----------------------------------------------------------------------------
module mmre_fifo import mmre_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tok_t                    push_tok,
	input  logic signed [ACC_W-1:0] push_sum,
	mmre_rsp_if.source              rsp,
	output fifo_stat_t              stat
);

	typedef struct packed {
		logic signed [ACC_W-1:0] sum;
		logic [IDX_W-1:0]        col;
		logic                    last;
	} entry_t;

	entry_t             mem_q [MAX_EMIT];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               push, pop;

	assign push = push_tok.valid;
	assign pop  = rsp.valid && rsp.ready;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (FIFO_AW+1)'(MAX_EMIT));

	assign rsp.valid         = !stat.empty;
	assign rsp.product_value = mem_q[rd_ptr_q].sum;
	assign rsp.out_col       = mem_q[rd_ptr_q].col;
	assign rsp.last          = mem_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{sum: push_sum, col: push_tok.col, last: push_tok.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("result queue overflow");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with empty count");

endmodule

// ===== rtl/core/matrix_multiply_row_engine_top.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_row_engine_top: matrix product engine, C = A * B
// Element stores for A and B spread over a chain of multiply-add cells;
// a compute request emits one row of C, one element per column.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink):  cmd 0 writes A[row][col], cmd 1 writes B[row][col], both
//                with a signed Q8.8 value; cmd 2 computes row 'row' of C.
//                Out-of-range writes, out-of-range computes and cmd 3 are
//                taken and dropped.
//   rsp (source): product_value is C[row][out_col] in signed Q20.16, columns
//                in increasing order, last set on the final column.
// Throughput: a new request is taken every cycle while no compute is running.
//   A compute holds off the next request while it latches the A row, feeds
//   NEMIT column tokens, then lets the three-stage-per-cell chain drain.
// Output: each element of the row passes through the cell chain and the
//   queue to rsp; elements then leave one per cycle while rsp.ready is high.
// Stall: results land in a queue that holds a full row, so the chain never
//   stops. A compute does not start feeding tokens until the queue is empty,
//   so a stalled receiver holds the next compute, and every request behind
//   it, until the previous row has been taken.
// Reset: arst_n clears the sequencer and queue; store contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module matrix_multiply_row_engine_top import mmre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mmre_req_if.sink   req,
	mmre_rsp_if.source rsp
);

	wr_t                     wr;
	logic [IDX_W-1:0]        row_sel;
	fifo_stat_t              fifo_stat;
	tok_t                    tok_chain  [INNER+1];
	logic signed [ACC_W-1:0] psum_chain [INNER+1];

	// Sequencer: decodes requests, feeds column tokens into cell 0
	mmre_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.fifo_stat (fifo_stat),
		.chain_tok (tok_chain[INNER]),
		.wr        (wr),
		.row_sel   (row_sel),
		.tok       (tok_chain[0])
	);

	assign psum_chain[0] = '0;

	// Cell k holds A[*][k] and B[k][*]; partial sums flow left to right
	for (genvar g = 0; g < INNER; g++) begin : g_cell
		mmre_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.k_idx    (IDX_W'(g)),
			.wr       (wr),
			.row_sel  (row_sel),
			.tok_in   (tok_chain[g]),
			.psum_in  (psum_chain[g]),
			.tok_out  (tok_chain[g+1]),
			.psum_out (psum_chain[g+1])
		);
	end

	// Finished sums from the last cell go to the result queue
	mmre_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_tok (tok_chain[INNER]),
		.push_sum (psum_chain[INNER]),
		.rsp      (rsp),
		.stat     (fifo_stat)
	);

	// A result leaving the chain never meets a full queue
	a_chain_room: assert property (@(posedge clk) disable iff (!arst_n)
		tok_chain[INNER].valid |-> !fifo_stat.full)
		else $error("chain result with full queue");

	// No request is taken while results are leaving the chain
	a_no_req_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		tok_chain[INNER].valid |-> !req.ready)
		else $error("request taken during compute");

	// Token feed stops right after the last column
	a_feed_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_chain[0].valid && tok_chain[0].last) |=> !tok_chain[0].valid)
		else $error("token feed ran past last column");

endmodule
